>>> rtl/slex_pkg.sv
// slex_pkg: shared types, token kind codes, lexer mode codes and keyword table
// for the script lexer. No dependencies.
package slex_pkg;

  localparam int POS_WIDTH_DEF = 16;
  localparam int FIFO_DEPTH    = 4;
  localparam int PTR_W         = $clog2(FIFO_DEPTH);
  localparam int CNT_W         = $clog2(FIFO_DEPTH + 1);

  // token kinds
  localparam logic [5:0] K_IDENT  = 6'd0;
  localparam logic [5:0] K_NUMBER = 6'd13;
  localparam logic [5:0] K_LPAREN = 6'd14;
  localparam logic [5:0] K_RPAREN = 6'd15;
  localparam logic [5:0] K_PLUS   = 6'd16;
  localparam logic [5:0] K_STAR   = 6'd17;
  localparam logic [5:0] K_SLASH  = 6'd18;
  localparam logic [5:0] K_PCT    = 6'd19;
  localparam logic [5:0] K_SEMI   = 6'd20;
  localparam logic [5:0] K_COMMA  = 6'd21;
  localparam logic [5:0] K_MINUS  = 6'd22;
  localparam logic [5:0] K_ASSIGN = 6'd24;
  localparam logic [5:0] K_BANG   = 6'd26;
  localparam logic [5:0] K_LT     = 6'd28;
  localparam logic [5:0] K_GT     = 6'd30;
  localparam logic [5:0] K_STRING = 6'd32;
  localparam logic [5:0] K_EOF    = 6'd33;
  localparam logic [5:0] K_ERROR  = 6'd34;

  // lexer modes
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_STRING  = 3'd3;
  localparam logic [2:0] MODE_COMMENT = 3'd4;
  localparam logic [2:0] MODE_PEND    = 3'd5;
  localparam logic [2:0] MODE_HALT    = 3'd6;

  // keywords packed first byte highest, kind is index + 1
  localparam int NUM_KW = 12;
  localparam logic [39:0] KW_TEXT [NUM_KW] = '{
    40'h00006C6574,  40'h0000006966, 40'h007468656E, 40'h00656C7365,
    40'h000000666E,  40'h0074727565, 40'h66616C7365, 40'h00006E696C,
    40'h0000616E64,  40'h0000006F72, 40'h000000646F, 40'h00646F6E65
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd3, 3'd2, 3'd4, 3'd4, 3'd2, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd2, 3'd4
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } slex_in_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start_pos;
    logic [15:0] length;
    logic [15:0] line;
    logic [7:0]  bad_char;
    logic        last;
  } slex_res_t;

  typedef struct packed {
    logic [1:0] n;
    slex_res_t  r0;
    slex_res_t  r1;
  } slex_push_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             room2;
  } slex_fifo_st_t;

  function automatic logic [5:0] kw_kind(logic [39:0] win, logic [2:0] len, logic short_ok);
    logic [5:0] k;
    k = K_IDENT;
    for (int i = 0; i < NUM_KW; i++) begin
      if (short_ok && len == KW_LEN[i] && win == KW_TEXT[i]) k = 6'(i + 1);
    end
    return k;
  endfunction

  function automatic slex_res_t mk_res(logic [5:0] kind, logic [15:0] start_pos,
                                       logic [15:0] length, logic [15:0] line,
                                       logic [7:0] bad_char);
    slex_res_t r;
    r.kind      = kind;
    r.start_pos = start_pos;
    r.length    = length;
    r.line      = line;
    r.bad_char  = bad_char;
    r.last      = 1'b0;
    return r;
  endfunction

endpackage

>>> rtl/slex_core.sv
// slex_core: lexer state and per-byte token decode, up to two tokens per beat.
// Depends on slex_pkg.
module slex_core #(
  parameter int POS_WIDTH = slex_pkg::POS_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  slex_pkg::slex_in_t   in_data,
  output slex_pkg::slex_push_t push
);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [POS_WIDTH-1:0] ONE  = POS_WIDTH'(1);
  localparam logic [POS_WIDTH-1:0] FIVE = POS_WIDTH'(5);

  logic [2:0]           mode_r,  mode_nxt;
  logic [7:0]           pend_r,  pend_nxt;
  logic [39:0]          win_r,   win_nxt;
  logic [POS_WIDTH-1:0] start_r, start_nxt;
  logic [POS_WIDTH-1:0] len_r,   len_nxt;
  logic [POS_WIDTH-1:0] pos_r,   pos_nxt;
  logic [POS_WIDTH-1:0] line_r,  line_nxt;

  logic [7:0] c;
  logic       is_end, is_space, is_letter, is_digit, is_pend_op, single_hit;
  logic [5:0] single_kind;

  logic                 idle_put;
  logic [5:0]           idle_kind;
  logic [7:0]           idle_bad;
  logic [2:0]           idle_mode;
  logic [7:0]           idle_pend;
  logic [39:0]          idle_win;
  logic [POS_WIDTH-1:0] idle_start, idle_len;
  slex_pkg::slex_res_t  idle_res, word_res, eof_res;

  logic [5:0] word_kind, pend_k;
  logic [7:0] want;
  logic       word_cont;

  logic [1:0]          n;
  slex_pkg::slex_res_t r0, r1;

  function automatic logic [POS_WIDTH-1:0] sat_inc(logic [POS_WIDTH-1:0] v);
    return (v == '1) ? v : v + ONE;
  endfunction

  assign c         = in_data.ch;
  assign is_end    = in_data.end_of_input || (c == 8'h00);
  assign is_space  = (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
  assign is_letter = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  assign is_digit  = (c >= 8'h30 && c <= 8'h39);
  assign is_pend_op = (c == CH_MINUS) || (c == CH_EQ) || (c == CH_BANG) ||
                      (c == CH_LT) || (c == CH_GT);

  always_comb begin
    single_hit  = 1'b1;
    single_kind = slex_pkg::K_ERROR;
    unique case (c)
      CH_LPAR:  single_kind = slex_pkg::K_LPAREN;
      CH_RPAR:  single_kind = slex_pkg::K_RPAREN;
      CH_PLUS:  single_kind = slex_pkg::K_PLUS;
      CH_STAR:  single_kind = slex_pkg::K_STAR;
      CH_SLASH: single_kind = slex_pkg::K_SLASH;
      CH_PCT:   single_kind = slex_pkg::K_PCT;
      CH_SEMI:  single_kind = slex_pkg::K_SEMI;
      CH_COMMA: single_kind = slex_pkg::K_COMMA;
      default:  single_hit  = 1'b0;
    endcase
  end

  // decode of a byte seen where a token may start
  always_comb begin
    idle_put   = 1'b0;
    idle_kind  = slex_pkg::K_ERROR;
    idle_bad   = 8'h00;
    idle_mode  = slex_pkg::MODE_IDLE;
    idle_pend  = pend_r;
    idle_win   = win_r;
    idle_start = start_r;
    idle_len   = len_r;
    if (is_space) begin
      idle_mode = slex_pkg::MODE_IDLE;
    end else if (c == CH_HASH) begin
      idle_mode = slex_pkg::MODE_COMMENT;
    end else if (is_letter || is_digit) begin
      idle_mode  = is_letter ? slex_pkg::MODE_IDENT : slex_pkg::MODE_NUMBER;
      idle_start = pos_r;
      idle_len   = ONE;
      idle_win   = {32'h0, c};
    end else if (c == CH_QUOTE) begin
      idle_mode  = slex_pkg::MODE_STRING;
      idle_start = pos_r;
      idle_len   = '0;
    end else if (is_pend_op) begin
      idle_mode  = slex_pkg::MODE_PEND;
      idle_pend  = c;
      idle_start = pos_r;
    end else if (single_hit) begin
      idle_put  = 1'b1;
      idle_kind = single_kind;
    end else begin
      idle_put  = 1'b1;
      idle_kind = slex_pkg::K_ERROR;
      idle_bad  = c;
      idle_mode = slex_pkg::MODE_HALT;
    end
  end

  always_comb begin
    unique case (pend_r)
      CH_MINUS: pend_k = slex_pkg::K_MINUS;
      CH_EQ:    pend_k = slex_pkg::K_ASSIGN;
      CH_BANG:  pend_k = slex_pkg::K_BANG;
      CH_LT:    pend_k = slex_pkg::K_LT;
      default:  pend_k = slex_pkg::K_GT;
    endcase
  end

  assign want      = (pend_r == CH_MINUS) ? CH_GT : CH_EQ;
  assign word_kind = (mode_r == slex_pkg::MODE_IDENT) ?
                     slex_pkg::kw_kind(win_r, len_r[2:0], len_r <= FIVE) :
                     slex_pkg::K_NUMBER;
  assign word_cont = (mode_r == slex_pkg::MODE_IDENT) ?
                     (is_letter || is_digit || c == CH_UNDER) :
                     (is_digit || c == CH_DOT);

  assign idle_res = slex_pkg::mk_res(idle_kind, 16'(pos_r), 16'd1, 16'(line_r), idle_bad);
  assign word_res = slex_pkg::mk_res(word_kind, 16'(start_r), 16'(len_r), 16'(line_r), 8'h00);
  assign eof_res  = slex_pkg::mk_res(slex_pkg::K_EOF, 16'(pos_r), 16'd0,
                                     16'(line_r - ONE), 8'h00);

  always_comb begin
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    win_nxt   = win_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    line_nxt  = line_r;
    n         = 2'd0;
    r0        = '0;
    r1        = '0;
    if (is_end) begin
      // flush whatever is pending, then eof, then back to reset state
      unique case (mode_r) inside
        slex_pkg::MODE_IDENT, slex_pkg::MODE_NUMBER: begin
          r0 = word_res;
          n  = 2'd1;
        end
        slex_pkg::MODE_PEND: begin
          r0 = slex_pkg::mk_res(pend_k, 16'(start_r), 16'd1, 16'(line_r), 8'h00);
          n  = 2'd1;
        end
        slex_pkg::MODE_STRING: begin
          r0 = slex_pkg::mk_res(slex_pkg::K_ERROR, 16'(start_r), 16'(len_r),
                                16'(line_r), CH_QUOTE);
          n  = 2'd1;
        end
        default: ;
      endcase
      if (n == 2'd0) r0 = eof_res;
      else           r1 = eof_res;
      n         = n + 2'd1;
      mode_nxt  = slex_pkg::MODE_IDLE;
      pend_nxt  = 8'h00;
      win_nxt   = '0;
      start_nxt = '0;
      len_nxt   = '0;
      pos_nxt   = '0;
      line_nxt  = ONE;
    end else begin
      unique case (mode_r) inside
        slex_pkg::MODE_IDENT, slex_pkg::MODE_NUMBER: begin
          if (word_cont) begin
            if (len_r < FIVE) win_nxt = {win_r[31:0], c};
            len_nxt = sat_inc(len_r);
          end else begin
            r0        = word_res;
            n         = 2'd1;
            mode_nxt  = idle_mode;
            pend_nxt  = idle_pend;
            win_nxt   = idle_win;
            start_nxt = idle_start;
            len_nxt   = idle_len;
            if (idle_put) begin
              r1 = idle_res;
              n  = 2'd2;
            end
          end
        end
        slex_pkg::MODE_STRING: begin
          if (c == CH_QUOTE) begin
            r0       = slex_pkg::mk_res(slex_pkg::K_STRING, 16'(start_r), 16'(len_r),
                                        16'(line_r), 8'h00);
            n        = 2'd1;
            mode_nxt = slex_pkg::MODE_IDLE;
          end else begin
            len_nxt = sat_inc(len_r);
          end
        end
        slex_pkg::MODE_COMMENT: begin
          if (c == CH_NL) mode_nxt = slex_pkg::MODE_IDLE;
        end
        slex_pkg::MODE_PEND: begin
          n        = 2'd1;
          mode_nxt = slex_pkg::MODE_IDLE;
          if (c == want) begin
            r0 = slex_pkg::mk_res(6'(pend_k + 6'd1), 16'(start_r), 16'd2,
                                  16'(line_r), 8'h00);
          end else begin
            // single operator, then the byte starts over
            r0        = slex_pkg::mk_res(pend_k, 16'(start_r), 16'd1, 16'(line_r), 8'h00);
            mode_nxt  = idle_mode;
            pend_nxt  = idle_pend;
            win_nxt   = idle_win;
            start_nxt = idle_start;
            len_nxt   = idle_len;
            if (idle_put) begin
              r1 = idle_res;
              n  = 2'd2;
            end
          end
        end
        slex_pkg::MODE_HALT: ;
        default: begin
          mode_nxt  = idle_mode;
          pend_nxt  = idle_pend;
          win_nxt   = idle_win;
          start_nxt = idle_start;
          len_nxt   = idle_len;
          if (idle_put) begin
            r0 = idle_res;
            n  = 2'd1;
          end
        end
      endcase
      if (c == CH_NL) line_nxt = sat_inc(line_r);
      pos_nxt = sat_inc(pos_r);
    end
    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= slex_pkg::MODE_IDLE;
      pend_r  <= 8'h00;
      win_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
      pos_r   <= '0;
      line_r  <= ONE;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      win_r   <= win_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      line_r  <= line_nxt;
    end
  end

  assign push.n  = accept ? n : 2'd0;
  assign push.r0 = r0;
  assign push.r1 = r1;

endmodule

>>> rtl/slex_fifo.sv
// slex_fifo: small result queue, takes up to two tokens per cycle and
// hands one per beat to the output. Depends on slex_pkg.
module slex_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  slex_pkg::slex_push_t    push,
  input  logic                    pop,
  output slex_pkg::slex_res_t     head,
  output slex_pkg::slex_fifo_st_t status
);

  localparam int PW = slex_pkg::PTR_W;
  localparam int CW = slex_pkg::CNT_W;

  slex_pkg::slex_res_t mem_r [slex_pkg::FIFO_DEPTH];
  logic [PW-1:0] rd_r, rd_nxt;
  logic [PW-1:0] wr_r, wr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign rd_nxt  = pop ? PW'(rd_r + PW'(1)) : rd_r;
  assign wr_nxt  = PW'(wr_r + PW'(push.n));
  assign cnt_nxt = CW'(cnt_r + CW'(push.n) - CW'(pop));

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wr_r] <= push.r0;
    if (push.n == 2'd2) mem_r[PW'(wr_r + PW'(1))] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      wr_r  <= '0;
      cnt_r <= '0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign head         = mem_r[rd_r];
  assign status.count = cnt_r;
  assign status.room2 = (cnt_r <= CW'(slex_pkg::FIFO_DEPTH - 2));

endmodule

>>> rtl/script_lexer.sv
// script_lexer: top level of the streaming lexer, core plus result queue.
// Depends on slex_pkg, slex_core and slex_fifo.

// One source byte is taken per beat unless in_stall is high, and decoded
// in the same cycle it is accepted; a byte yields zero, one or two tokens,
// which enter a four-entry result queue and leave one per beat. The input
// stalls while fewer than two queue entries are free, so while the receiver
// does not stall the sustained rate is one byte per cycle except where bytes
// yield two tokens each, where the single output beat per cycle sets the
// pace. A byte 0 or end_of_input flushes the pending token, emits eof and
// clears the lexer state. Position, length and line counters are POS_WIDTH
// bits wide and saturate; results carry their low 16 bits.
module script_lexer #(
  parameter int POS_WIDTH = slex_pkg::POS_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  slex_pkg::slex_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output slex_pkg::slex_res_t out_data
);

  logic                    accept;
  logic                    pop;
  slex_pkg::slex_push_t    push;
  slex_pkg::slex_fifo_st_t fst;

  assign in_stall  = !fst.room2;
  assign accept    = in_valid && !in_stall;
  assign out_valid = (fst.count != '0);
  assign pop       = out_valid && !out_stall;

  slex_core #(
    .POS_WIDTH (POS_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .push    (push)
  );

  slex_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (pop),
    .head   (out_data),
    .status (fst)
  );

  // queue never overfills
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fst.count <= slex_pkg::CNT_W'(slex_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // end of input always produces at least the eof token
  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.end_of_input || in_data.ch == 8'h00)) |-> push.n != 2'd0)
    else $error("end of input without eof");

  // last flag sits on the final token of a beat only
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |->
      ((push.n == 2'd1 && push.r0.last) ||
       (push.n == 2'd2 && push.r1.last && !push.r0.last)))
    else $error("last flag misplaced");

  // no push without an accepted byte
  a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> push.n == 2'd0)
    else $error("tokens pushed without input");

endmodule

>>> bench/script_lexer_tb.sv
`timescale 1ns / 100ps
// script_lexer_tb: self-checking bench for the streaming script lexer, with a token
// predictor and scoreboard class and random program generation. Depends on slex_pkg and
// script_lexer.
module script_lexer_tb;

  class token_scoreboard;
    logic [2:0]  mode;
    logic [7:0]  pend_op;
    logic [39:0] kw_win;
    logic [15:0] tok_start;
    logic [15:0] tok_len;
    logic [15:0] pos;
    logic [15:0] line_no;
    slex_pkg::slex_res_t step_tokens[$];
    slex_pkg::slex_res_t pending_tokens[$];
    int          n_errors;
    int          n_checked;

    function new();
      n_errors  = 0;
      n_checked = 0;
      clear_state();
    endfunction

    function void clear_state();
      mode      = slex_pkg::MODE_IDLE;
      pend_op   = 8'h00;
      kw_win    = '0;
      tok_start = '0;
      tok_len   = '0;
      pos       = '0;
      line_no   = 16'd1;
    endfunction

    function logic [15:0] sat_inc(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_space(logic [7:0] c);
      return c == " " || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function void add_token(logic [5:0] kind, logic [15:0] start_pos, logic [15:0] length,
                            logic [15:0] line, logic [7:0] bad_char);
      slex_pkg::slex_res_t t;
      t.kind      = kind;
      t.start_pos = start_pos;
      t.length    = length;
      t.line      = line;
      t.bad_char  = bad_char;
      t.last      = 1'b0;
      step_tokens.push_back(t);
    endfunction

    // keyword text packed first byte highest, compared with the length
    function logic [5:0] word_kind();
      string       kw [12] = '{"let", "if", "then", "else", "fn", "true",
                               "false", "nil", "and", "or", "do", "done"};
      logic [39:0] word_bits;
      for (int i = 0; i < 12; i++) begin
        word_bits = '0;
        for (int j = 0; j < kw[i].len(); j++) word_bits = {word_bits[31:0], kw[i][j]};
        if (kw[i].len() == tok_len && word_bits == kw_win) return 6'(i + 1);
      end
      return slex_pkg::K_IDENT;
    endfunction

    function void emit_word();
      add_token((mode == slex_pkg::MODE_IDENT) ? word_kind() : slex_pkg::K_NUMBER,
                tok_start, tok_len, line_no, 8'h00);
      mode = slex_pkg::MODE_IDLE;
    endfunction

    function logic [5:0] pend_kind(logic [7:0] c);
      case (c)
        "-": return slex_pkg::K_MINUS;
        "=": return slex_pkg::K_ASSIGN;
        "!": return slex_pkg::K_BANG;
        "<": return slex_pkg::K_LT;
        default: return slex_pkg::K_GT;
      endcase
    endfunction

    function void lex_start(logic [7:0] c);
      logic [5:0] k;
      bit         single;
      k      = slex_pkg::K_IDENT;
      single = 1'b1;
      if (is_space(c)) return;
      if (c == "#") begin
        mode = slex_pkg::MODE_COMMENT;
        return;
      end
      if (is_letter(c) || is_digit(c)) begin
        mode      = is_letter(c) ? slex_pkg::MODE_IDENT : slex_pkg::MODE_NUMBER;
        tok_start = pos;
        tok_len   = 16'd1;
        kw_win    = {32'h0, c};
        return;
      end
      if (c == "\"") begin
        mode      = slex_pkg::MODE_STRING;
        tok_start = pos;
        tok_len   = '0;
        return;
      end
      case (c)
        "(": k = slex_pkg::K_LPAREN;
        ")": k = slex_pkg::K_RPAREN;
        "+": k = slex_pkg::K_PLUS;
        "*": k = slex_pkg::K_STAR;
        "/": k = slex_pkg::K_SLASH;
        "%": k = slex_pkg::K_PCT;
        ";": k = slex_pkg::K_SEMI;
        ",": k = slex_pkg::K_COMMA;
        "-", "=", "!", "<", ">": begin
          mode      = slex_pkg::MODE_PEND;
          pend_op   = c;
          tok_start = pos;
          return;
        end
        default: single = 1'b0;
      endcase
      if (single) begin
        add_token(k, pos, 16'd1, line_no, 8'h00);
      end else begin
        add_token(slex_pkg::K_ERROR, pos, 16'd1, line_no, c);
        mode = slex_pkg::MODE_HALT;
      end
    endfunction

    function void note_byte(slex_pkg::slex_in_t beat);
      logic [7:0] c;
      logic [7:0] want;
      logic [5:0] k;
      bit         finish;
      c      = beat.ch;
      finish = beat.end_of_input || c == 8'h00;
      step_tokens.delete();
      if (finish) begin
        if (mode == slex_pkg::MODE_IDENT || mode == slex_pkg::MODE_NUMBER) begin
          emit_word();
        end else if (mode == slex_pkg::MODE_PEND) begin
          add_token(pend_kind(pend_op), tok_start, 16'd1, line_no, 8'h00);
        end else if (mode == slex_pkg::MODE_STRING) begin
          add_token(slex_pkg::K_ERROR, tok_start, tok_len, line_no, 8'h22);
        end
        add_token(slex_pkg::K_EOF, pos, 16'd0, line_no - 16'd1, 8'h00);
        clear_state();
      end else begin
        case (mode)
          slex_pkg::MODE_IDENT, slex_pkg::MODE_NUMBER: begin
            if ((mode == slex_pkg::MODE_IDENT && (is_letter(c) || is_digit(c) || c == "_")) ||
                (mode == slex_pkg::MODE_NUMBER && (is_digit(c) || c == "."))) begin
              if (tok_len < 16'd5) kw_win = {kw_win[31:0], c};
              tok_len = sat_inc(tok_len);
            end else begin
              emit_word();
              lex_start(c);
            end
          end
          slex_pkg::MODE_STRING: begin
            if (c == "\"") begin
              add_token(slex_pkg::K_STRING, tok_start, tok_len, line_no, 8'h00);
              mode = slex_pkg::MODE_IDLE;
            end else begin
              tok_len = sat_inc(tok_len);
            end
          end
          slex_pkg::MODE_COMMENT: if (c == 8'h0A) mode = slex_pkg::MODE_IDLE;
          slex_pkg::MODE_PEND: begin
            k    = pend_kind(pend_op);
            want = (pend_op == "-") ? 8'(">") : 8'("=");
            mode = slex_pkg::MODE_IDLE;
            if (c == want) begin
              add_token(k + 6'd1, tok_start, 16'd2, line_no, 8'h00);
            end else begin
              add_token(k, tok_start, 16'd1, line_no, 8'h00);
              lex_start(c);
            end
          end
          slex_pkg::MODE_HALT: ;
          default: lex_start(c);
        endcase
        if (c == 8'h0A) line_no = sat_inc(line_no);
        pos = sat_inc(pos);
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
    endfunction

    task report_mismatch(string field, int got, int want);
      if (n_errors < 40)
        $display("%0t: token %0d %s mismatch: got %0d, expected %0d",
                 $time, n_checked, field, got, want);
      n_errors++;
    endtask

    task check_token(slex_pkg::slex_res_t got);
      slex_pkg::slex_res_t want;
      if (pending_tokens.size() == 0) begin
        report_mismatch("unexpected token kind", got.kind, 0);
        n_checked++;
        return;
      end
      want = pending_tokens.pop_front();
      if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
      if (got.start_pos != want.start_pos)
        report_mismatch("start_pos", got.start_pos, want.start_pos);
      if (got.length != want.length) report_mismatch("length", got.length, want.length);
      if (got.line != want.line) report_mismatch("line", got.line, want.line);
      if (got.bad_char != want.bad_char)
        report_mismatch("bad_char", got.bad_char, want.bad_char);
      if (got.last != want.last) report_mismatch("last", got.last, want.last);
      n_checked++;
    endtask
  endclass

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  slex_pkg::slex_in_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  slex_pkg::slex_res_t out_data;

  token_scoreboard sb;
  bit    burst     = 1'b0;
  bit    hold_off  = 1'b0;
  int    sent_items = 0;
  string kw_list [12] = '{"let", "if", "then", "else", "fn", "true",
                          "false", "nil", "and", "or", "do", "done"};

  script_lexer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_byte(logic [7:0] c, logic e);
    slex_pkg::slex_in_t beat;
    int       gap;
    beat.ch           = c;
    beat.end_of_input = e;
    gap = burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    sb.note_byte(beat);
    sent_items++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic wait_all_tokens();
    in_valid <= 1'b0;
    while (sb.pending_tokens.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    int pick;
    pick = $urandom_range(0, 51);
    return (pick < 26) ? 8'("a" + pick) : 8'("A" + pick - 26);
  endfunction

  function automatic logic [7:0] rand_space();
    logic [7:0] ws [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    return ws[$urandom_range(0, 5)];
  endfunction

  // mostly well-formed token streams, some noise and cut-off strings
  task automatic send_program();
    logic [7:0] src[$];
    logic [7:0] c;
    string      s;
    string      ops;
    string      pairs [5] = '{"->", "==", "!=", "<=", ">="};
    int         n_tok;
    int         r;
    ops   = "()+*/%;,-=!<>";
    n_tok = $urandom_range(0, 12);
    for (int t = 0; t < n_tok; t++) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        s = kw_list[$urandom_range(0, 11)];
        for (int i = 0; i < s.len(); i++) src.push_back(s[i]);
        // a capital letter turns it into a plain identifier
        if ($urandom_range(0, 7) == 0) src[src.size() - 1] = src[src.size() - 1] - 8'd32;
      end else if (r < 35) begin
        src.push_back(rand_letter());
        repeat ($urandom_range(0, 8)) begin
          case ($urandom_range(0, 3))
            0: c = 8'("0" + $urandom_range(0, 9));
            1: c = "_";
            default: c = rand_letter();
          endcase
          src.push_back(c);
        end
      end else if (r < 47) begin
        src.push_back(8'("0" + $urandom_range(0, 9)));
        repeat ($urandom_range(0, 5))
          src.push_back(($urandom_range(0, 3) == 0) ? 8'(".") : 8'("0" + $urandom_range(0, 9)));
      end else if (r < 57) begin
        src.push_back("\"");
        repeat ($urandom_range(0, 6)) begin
          c = 8'($urandom_range(1, 255));
          src.push_back((c == "\"") ? 8'("q") : c);
        end
        src.push_back("\"");
      end else if (r < 82) begin
        r = $urandom_range(0, 17);
        if (r < 13) begin
          src.push_back(ops[r]);
        end else begin
          src.push_back(pairs[r - 13][0]);
          src.push_back(pairs[r - 13][1]);
        end
      end else if (r < 87) begin
        src.push_back("#");
        repeat ($urandom_range(0, 6)) begin
          c = 8'($urandom_range(1, 255));
          src.push_back((c == 8'h0A) ? 8'("x") : c);
        end
        src.push_back(8'h0A);
      end else if (r < 97) begin
        src.push_back(rand_space());
      end else begin
        src.push_back(8'($urandom_range(1, 255)));
      end
      if ($urandom_range(0, 9) < 6) src.push_back(rand_space());
    end
    if ($urandom_range(0, 9) == 0) begin
      src.push_back("\"");
      repeat ($urandom_range(0, 4)) src.push_back(rand_letter());
    end
    burst = ($urandom_range(0, 3) == 0);
    foreach (src[i]) send_byte(src[i], 1'b0);
    if ($urandom_range(0, 1) == 1) send_byte(8'($urandom_range(0, 255)), 1'b1);
    else send_byte(8'h00, 1'b0);
  endtask

  // result side: random stall per beat, calm stretches, one long hold on request
  initial begin
    int  n;
    bit  calm;
    calm = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off) begin
        n        = 300;
        hold_off = 1'b0;
      end else begin
        n = calm ? 0 : $urandom_range(0, 15);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_token(out_data);
      if ($urandom_range(0, 39) == 0) calm = !calm;
    end
  end

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ident with underscore, pending minus flushed at end, ch ignored on end
    send_text("x1_ -");
    send_byte(8'hFF, 1'b1);
    // ident cut by operator, two-char pair, unterminated string at byte 0
    send_text("a<=\"q");
    send_byte(8'h00, 1'b0);
    // comment, number with dot, single op then unexpected byte, halted bytes
    send_text("#c\n9.>");
    send_byte(8'hFF, 1'b0);
    send_text("z\n");
    send_byte(8'h00, 1'b1);

    // fill the result queue while the receiver holds off
    hold_off = 1'b1;
    burst    = 1'b1;
    repeat (8) send_text("(+*;,)");
    send_byte(8'h00, 1'b1);
    wait_all_tokens();

    sent_items = 0;
    while (sent_items < 1000) send_program();

    wait_all_tokens();
    repeat (32) @(posedge clk);
    if (sb.n_errors == 0 && sb.pending_tokens.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/slex_pkg.sv
rtl/slex_core.sv
rtl/slex_fifo.sv
rtl/script_lexer.sv
bench/script_lexer_tb.sv
